FILE: hdl/morton_hilbert_3d_converter_macros.svh
// Assertion helpers shared by the converter RTL.
`ifndef MORTON_HILBERT_3D_CONVERTER_MACROS_SVH
`define MORTON_HILBERT_3D_CONVERTER_MACROS_SVH

// Check a whole property, disabled while reset is asserted.
`define MH3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that cons holds in the cycle after ante.
`define MH3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mh3_pkg.sv
`default_nettype none
package mh3_pkg;

    localparam logic [3:0]  MAX_LEVELS  = 4'd10;
    localparam int          NUM_CELLS   = int'(MAX_LEVELS) - 1;

    localparam logic [31:0] LANE_MASK   = 32'h9249_2492;
    localparam logic [31:0] ROT_TABLE   = 32'h2021_2021;
    localparam logic [7:0]  SHIFT_TABLE = 8'h48;
    localparam logic [31:0] SIGN_TABLE  = 32'h5356_0300;

    typedef enum logic {
        REQ_TO_HILBERT = 1'b0,
        REQ_TO_MORTON  = 1'b1
    } mh3_dir_t;

    // Word in flight along the level chain
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  sel;
        logic [1:0]  rot;
        logic [2:0]  sgn;
        mh3_dir_t    dir;
        logic [3:0]  levels;
    } mh3_flow_t;

    // Bit offset of a 3-bit digit
    function automatic logic [4:0] digit_pos(logic [3:0] idx);
        return {idx, 1'b0} + {1'b0, idx};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/mh3_cell.sv
`default_nettype none
module mh3_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [3:0]       digit_idx,
    input  wire logic             in_valid,
    input  wire mh3_pkg::mh3_flow_t in_flow,
    output logic                  out_valid,
    output mh3_pkg::mh3_flow_t    out_flow
);
    import mh3_pkg::*;
    `include "morton_hilbert_3d_converter_macros.svh"

    logic        valid_reg, valid_next;
    mh3_flow_t   flow_reg, flow_next;

    logic        active;
    logic [4:0]  sel_sh;
    logic [4:0]  pos;
    logic [1:0]  m;
    logic [2:0]  rot_idx;
    logic [1:0]  rot_new;
    logic [5:0]  sgn_dup;
    logic [2:0]  sgn_new;
    logic [2:0]  src;
    logic [2:0]  dst;
    logic [31:0] dmask;

    function automatic logic [2:0] rot3(logic [2:0] d, logic [1:0] r);
        logic [5:0] dd;
        dd = {d, d};
        return 3'(dd >> r);
    endfunction

    // The cell rewrites its digit only when it lies below the top level
    assign active  = ({1'b0, in_flow.levels}) >= ({1'b0, digit_idx} + 5'd2);
    assign sel_sh  = {in_flow.sel, 2'b00};
    assign pos     = digit_pos(digit_idx);
    assign dmask   = 32'h7 << pos;
    assign m       = 2'(ROT_TABLE >> sel_sh);
    assign rot_idx = (in_flow.dir == REQ_TO_HILBERT)
                   ? (3'd7 - {1'b0, in_flow.rot} - {1'b0, m})
                   : (3'd4 - {1'b0, in_flow.rot} + {1'b0, m});
    assign rot_new = 2'(SHIFT_TABLE >> rot_idx);
    assign sgn_dup = {in_flow.sgn, in_flow.sgn};
    assign sgn_new = 3'(sgn_dup >> m) ^ 3'(SIGN_TABLE >> sel_sh);
    assign src     = 3'(in_flow.word >> pos);
    assign dst     = (in_flow.dir == REQ_TO_HILBERT)
                   ? (rot3(src, rot_new) ^ sgn_new)
                   : rot3(src ^ sgn_new, rot_new);

    always_comb
    begin
        valid_next = in_valid;
        flow_next  = in_flow;
        if (active)
        begin
            flow_next.word = in_flow.word ^ ({29'd0, src ^ dst} << pos);
            flow_next.rot  = rot_new;
            flow_next.sgn  = sgn_new;
            flow_next.sel  = (in_flow.dir == REQ_TO_HILBERT) ? dst : src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flow_reg <= flow_next;
    end

    assign out_valid = valid_reg;
    assign out_flow  = flow_reg;

    `MH3_ASSERT_NEXT(a_idle_cell_passes, clk, rst_n, in_valid && !active, flow_reg == $past(in_flow), "idle cell altered the word")
    `MH3_ASSERT_NEXT(a_own_digit_only, clk, rst_n, in_valid, ((flow_reg.word ^ $past(in_flow.word)) & ~$past(dmask)) == 32'd0, "cell touched a foreign digit")

endmodule
`default_nettype wire

FILE: hdl/morton_hilbert_3d_converter.sv
`default_nettype none
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+------------------------------
// request   | req_type, code_in              | taken when start && !busy
// result    | code_out                       | valid for one cycle with done
// config    | level_count                    | written when level_count_we
//
// One word enters per cycle; busy stays low. The accepting edge loads the
// entry register, the word then passes each of the nine level cells of the
// chain in order, and the output register raises done with its result.
// rst_n clears the pipeline valid bits and sets level_count back to 10.
// done is a single-cycle pulse; the receiver cannot stall it.
module morton_hilbert_3d_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [0:0]  req_type,
    input  wire logic [31:0] code_in,
    output logic             done,
    output logic [31:0]      code_out,
    input  wire logic        level_count_we,
    input  wire logic [3:0]  level_count
);
    import mh3_pkg::*;
    `include "morton_hilbert_3d_converter_macros.svh"

    // Level count register, saturated on use
    logic [3:0]  level_count_reg, level_count_next;
    logic [3:0]  levels_sat;

    // Entry stage
    logic        s0_valid_reg, s0_valid_next;
    mh3_flow_t   s0_flow_reg, s0_flow_next;
    logic        accept;
    mh3_dir_t    dir_in;
    logic [31:0] pre_word;
    logic [3:0]  top_idx;

    // Exit stage
    logic        done_reg, done_next;
    logic [31:0] code_out_reg, code_out_next;

    // Chain taps: index 0 is the entry register, NUM_CELLS the last cell
    logic        chain_valid [NUM_CELLS+1];
    mh3_flow_t   chain_flow  [NUM_CELLS+1];

    // Gray step taken last on the way to Hilbert order
    function automatic logic [31:0] gray_fwd(logic [31:0] w);
        logic [31:0] t;
        t = w ^ ((w >> 1) & LANE_MASK);
        return t ^ ((t & LANE_MASK) >> 1);
    endfunction

    // Its inverse, taken first on the way back to Morton order
    function automatic logic [31:0] gray_inv(logic [31:0] w);
        logic [31:0] t;
        t = w ^ ((w & LANE_MASK) >> 1);
        return t ^ ((t >> 1) & LANE_MASK);
    endfunction

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign dir_in = mh3_dir_t'(req_type);

    // Hold the level count between writes
    always_comb
    begin
        level_count_next = level_count_reg;
        if (level_count_we)
        begin
            level_count_next = level_count;
        end
    end

    assign levels_sat = (level_count_reg > MAX_LEVELS) ? MAX_LEVELS : level_count_reg;
    assign top_idx    = (levels_sat == 4'd0) ? 4'd0 : (levels_sat - 4'd1);
    assign pre_word   = (dir_in == REQ_TO_MORTON) ? gray_inv(code_in) : code_in;

    // Load the entry register: pre-step the word, seed the selector
    // from the top digit, and clear the rotation and sign state
    always_comb
    begin
        s0_valid_next       = accept;
        s0_flow_next.word   = pre_word;
        s0_flow_next.sel    = 3'(pre_word >> digit_pos(top_idx));
        s0_flow_next.rot    = 2'd0;
        s0_flow_next.sgn    = 3'd0;
        s0_flow_next.dir    = dir_in;
        s0_flow_next.levels = levels_sat;
    end

    assign chain_valid[0] = s0_valid_reg;
    assign chain_flow[0]  = s0_flow_reg;

    // Cell k rewrites digit NUM_CELLS-1-k, walking from the top level down
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        mh3_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .digit_idx (4'(NUM_CELLS - 1 - k)),
            .in_valid  (chain_valid[k]),
            .in_flow   (chain_flow[k]),
            .out_valid (chain_valid[k+1]),
            .out_flow  (chain_flow[k+1])
        );
    end

    // Finish the Hilbert direction with the Gray step, pass Morton as is
    always_comb
    begin
        done_next     = chain_valid[NUM_CELLS];
        code_out_next = (chain_flow[NUM_CELLS].dir == REQ_TO_HILBERT)
                      ? gray_fwd(chain_flow[NUM_CELLS].word)
                      : chain_flow[NUM_CELLS].word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= MAX_LEVELS;
            s0_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            level_count_reg <= level_count_next;
            s0_valid_reg    <= s0_valid_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers advance every cycle
    always_ff @(posedge clk)
    begin
        s0_flow_reg  <= s0_flow_next;
        code_out_reg <= code_out_next;
    end

    assign done     = done_reg;
    assign code_out = code_out_reg;

    `MH3_ASSERT(a_word_returns, clk, rst_n, accept |-> ##11 done,
        "accepted word produced no result")
    `MH3_ASSERT(a_levels_saturated, clk, rst_n,
        s0_valid_reg |-> (s0_flow_reg.levels <= MAX_LEVELS), "level count not saturated")
    `MH3_ASSERT_NEXT(a_no_stray_done, clk, rst_n, !chain_valid[NUM_CELLS], !done,
        "result without a word in the chain")

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import mh3_pkg::*;

    // Lookup words of the curve, kept apart from the package copies so the
    // prediction stands on its own.
    localparam logic [31:0] GRAY_LANES = 32'h9249_2492;
    localparam logic [31:0] ROT_WORD   = 32'h2021_2021;
    localparam logic [31:0] SHIFT_WORD = 32'h0000_0048;
    localparam logic [31:0] SIGN_WORD  = 32'h5356_0300;
    localparam logic [3:0]  TOP_LEVELS = 4'd10;
    localparam logic [3:0]  RESET_LEVELS = 4'd10;

    // Pipeline depth from entry register to done.
    localparam int PIPE_DEPTH  = 11;
    localparam int CYCLE_LIMIT = 200000;

    localparam int WORDS_PER_PHASE = 40;
    localparam int NUM_PHASES      = 10;
    localparam int NUM_PROBES      = 22;

    // Level settings walked by the random phases: extremes, saturating
    // values and the reset value again at the end.
    localparam logic [3:0] LEVEL_PLAN [0:NUM_PHASES-1] = '{
        4'd10, 4'd0, 4'd1, 4'd15, 4'd3, 4'd7, 4'd11, 4'd2, 4'd9, 4'd10
    };

    // Sender idle odds per phase, in percent. The third slot stands for the
    // receiver-stall phase; done cannot be held off, so it runs with no gaps.
    localparam int IDLE_PLAN [0:3] = '{0, 77, 0, 37};

    // One row of the directed table: level setting, direction, source code,
    // and the result where it is known by hand.
    typedef struct packed {
        logic [3:0]  lvl;
        mh3_dir_t    dir;
        logic [31:0] code;
        logic        known;
        logic [31:0] result;
    } probe_t;

    // Rows that share a level setting stand together; the first group runs
    // on the reset value of the register without any write.
    localparam probe_t PROBES [0:NUM_PROBES-1] = '{
        // reset level count: zero maps to zero both ways
        '{4'd10, REQ_TO_HILBERT, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{4'd10, REQ_TO_MORTON,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{4'd10, REQ_TO_HILBERT, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{4'd10, REQ_TO_MORTON,  32'hFFFF_FFFF, 1'b0, 32'h0},
        // top digit and the two bits above the top level
        '{4'd10, REQ_TO_HILBERT, 32'h2000_0000, 1'b0, 32'h0},
        '{4'd10, REQ_TO_MORTON,  32'h3800_0000, 1'b0, 32'h0},
        '{4'd10, REQ_TO_HILBERT, 32'hC000_0000, 1'b0, 32'h0},
        '{4'd10, REQ_TO_MORTON,  32'hC000_0007, 1'b0, 32'h0},
        '{4'd10, REQ_TO_HILBERT, 32'h1234_5678, 1'b0, 32'h0},
        '{4'd10, REQ_TO_MORTON,  32'h89AB_CDEF, 1'b0, 32'h0},
        // level count zero: Gray step only
        '{4'd0,  REQ_TO_HILBERT, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{4'd0,  REQ_TO_HILBERT, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{4'd0,  REQ_TO_MORTON,  32'hAAAA_AAAA, 1'b0, 32'h0},
        // level count one: Gray step only
        '{4'd1,  REQ_TO_HILBERT, 32'h0000_0007, 1'b0, 32'h0},
        '{4'd1,  REQ_TO_MORTON,  32'h9249_2492, 1'b0, 32'h0},
        // oversized level counts saturate at ten
        '{4'd15, REQ_TO_HILBERT, 32'hDEAD_BEEF, 1'b0, 32'h0},
        '{4'd15, REQ_TO_MORTON,  32'hDEAD_BEEF, 1'b0, 32'h0},
        '{4'd11, REQ_TO_HILBERT, 32'h5555_5555, 1'b0, 32'h0},
        // short walk: bits above the top level pass the walk untouched
        '{4'd4,  REQ_TO_HILBERT, 32'hFFFF_F5A3, 1'b0, 32'h0},
        '{4'd4,  REQ_TO_MORTON,  32'hABCD_E123, 1'b0, 32'h0},
        // two levels: a single digit is rewritten
        '{4'd2,  REQ_TO_HILBERT, 32'h0000_003F, 1'b0, 32'h0},
        '{4'd2,  REQ_TO_MORTON,  32'h0000_003F, 1'b0, 32'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [0:0]  req_type;
    logic [31:0] code_in;
    logic        done;
    logic [31:0] code_out;
    logic        level_count_we;
    logic [3:0]  level_count;

    // Converted codes still owed by the block, oldest first.
    logic [31:0] expected_codes [$];

    // Mirror of the level register, updated when a write lands.
    logic [3:0]  cfg_levels;
    logic [31:0] last_result;
    int          error_count;
    int          cycle_count;

    morton_hilbert_3d_converter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .code_in        (code_in),
        .done           (done),
        .code_out       (code_out),
        .level_count_we (level_count_we),
        .level_count    (level_count)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Free-running cycle count; end the run if it ever gets this far.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Rotate a 3-bit digit right by r within its own three bits.
    function automatic logic [31:0] rotate_digit(logic [31:0] d, logic [31:0] r);
        return ((d | (d << 3)) >> (r & 32'd3)) & 32'd7;
    endfunction

    // Walk the levels from the top digit down, rewriting each digit below the
    // top one, then apply the Gray step over the whole word.
    function automatic logic [31:0] hilbert_of_morton(logic [31:0] code, logic [31:0] n);
        logic [31:0] w, pos, sel, rot, sgn, m, src, dst;
        w = code;
        if (n > 32'd1)
        begin
            pos = n * 32'd3 - 32'd3;
            sel = (w >> pos) & 32'd7;
            rot = 32'd0;
            sgn = 32'd0;
            while (pos != 32'd0)
            begin
                pos = pos - 32'd3;
                sel = (sel & 32'd7) << 2;
                m   = (ROT_WORD >> sel) & 32'd3;
                rot = (SHIFT_WORD >> ((32'd7 - rot - m) & 32'd31)) & 32'd3;
                sgn = (sgn | (sgn << 3)) >> m;
                sgn = (sgn ^ (SIGN_WORD >> sel)) & 32'd7;
                src = (w >> pos) & 32'd7;
                dst = rotate_digit(src, rot) ^ sgn;
                w   = w ^ ((src ^ dst) << pos);
                sel = dst;
            end
        end
        w = w ^ ((w >> 1) & GRAY_LANES);
        w = w ^ ((w & GRAY_LANES) >> 1);
        return w;
    endfunction

    // Undo the Gray step first, then walk the levels; the next selector
    // comes from the source digit rather than the rewritten one.
    function automatic logic [31:0] morton_of_hilbert(logic [31:0] code, logic [31:0] n);
        logic [31:0] w, pos, sel, rot, sgn, m, src, dst;
        w = code;
        w = w ^ ((w & GRAY_LANES) >> 1);
        w = w ^ ((w >> 1) & GRAY_LANES);
        if (n > 32'd1)
        begin
            pos = n * 32'd3 - 32'd3;
            sel = (w >> pos) & 32'd7;
            rot = 32'd0;
            sgn = 32'd0;
            while (pos != 32'd0)
            begin
                pos = pos - 32'd3;
                sel = (sel & 32'd7) << 2;
                m   = (ROT_WORD >> sel) & 32'd3;
                rot = (SHIFT_WORD >> ((32'd4 - rot + m) & 32'd31)) & 32'd3;
                sgn = (sgn | (sgn << 3)) >> m;
                sgn = (sgn ^ (SIGN_WORD >> sel)) & 32'd7;
                src = (w >> pos) & 32'd7;
                dst = rotate_digit(src ^ sgn, rot);
                w   = w ^ ((src ^ dst) << pos);
                sel = src;
            end
        end
        return w;
    endfunction

    function automatic logic [31:0] convert_code(mh3_dir_t dir, logic [31:0] code,
                                                 logic [3:0] lvl);
        logic [31:0] n;
        // clamp the level count at ten
        n = (lvl > TOP_LEVELS) ? 32'(TOP_LEVELS) : 32'(lvl);
        if (dir == REQ_TO_MORTON)
            return morton_of_hilbert(code, n);
        return hilbert_of_morton(code, n);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one word: idle with the given odds, present the word at a falling
    // edge, hold it until a rising edge finds busy low, then log the
    // converted code it is owed.
    task automatic send_word(input mh3_dir_t dir, input logic [31:0] code,
                             input logic known, input logic [31:0] typed,
                             input int idle_pct);
        logic [31:0] owed;
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start    = 1'b0;
            req_type = 1'($urandom_range(1));
            code_in  = $urandom;
        end
        @(negedge clk);
        start    = 1'b1;
        req_type = dir;
        code_in  = code;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        owed = known ? typed : convert_code(dir, code, cfg_levels);
        expected_codes.push_back(owed);
        last_result = owed;
    endtask

    // Drop start and hold off until every owed code has come back.
    task automatic drain_results;
        @(negedge clk);
        start = 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
    endtask

    // Write the level register; only ever called with the pipeline empty.
    task automatic write_levels(input logic [3:0] value);
        @(negedge clk);
        level_count_we = 1'b1;
        level_count    = value;
        @(negedge clk);
        level_count_we = 1'b0;
        level_count    = 4'($urandom);
        cfg_levels     = value;
    endtask

    // Pick a source code: mostly full-width random, with sparse words,
    // single bits, words confined to the active levels, and round trips of
    // the last converted code.
    function automatic logic [31:0] pick_code(logic [3:0] lvl);
        int          kind;
        logic [31:0] n;
        kind = $urandom_range(9);
        n    = (lvl > TOP_LEVELS) ? 32'(TOP_LEVELS) : 32'(lvl);
        case (kind)
            6:       return $urandom & ((32'd1 << (n * 32'd3)) - 32'd1);
            7:       return 32'd1 << $urandom_range(31);
            8:       return last_result;
            9:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking: one code_out per done pulse, against the oldest owed code.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [31:0] owed;
        if (rst_n && done)
        begin
            if (expected_codes.size() == 0)
                report_mismatch($sformatf("done with nothing owed, code_out=%08h",
                                          code_out));
            else
            begin
                owed = expected_codes.pop_front();
                if (code_out !== owed)
                    report_mismatch($sformatf("code_out=%08h, want %08h",
                                              code_out, owed));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        mh3_dir_t dir;
        int       phase;
        int       k;

        // Drive every input to a known value before the first edge.
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = 1'b0;
        code_in        = 32'h0;
        level_count_we = 1'b0;
        level_count    = 4'h0;
        cfg_levels     = RESET_LEVELS;
        last_result    = 32'h0;
        error_count    = 0;
        cycle_count    = 0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed table; the first rows rely on the reset level count.
        for (k = 0; k < NUM_PROBES; k++)
        begin
            if (PROBES[k].lvl != cfg_levels)
            begin
                drain_results();
                write_levels(PROBES[k].lvl);
            end
            send_word(PROBES[k].dir, PROBES[k].code, PROBES[k].known,
                      PROBES[k].result, 0);
        end

        // Random phases: drain, change the level count, then stream words
        // under the idle odds of the phase.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            write_levels(LEVEL_PLAN[phase]);
            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                dir = mh3_dir_t'($urandom_range(1));
                // round trips only make sense in the reverse direction
                send_word(dir, pick_code(cfg_levels), 1'b0, 32'h0,
                          IDLE_PLAN[phase % 4]);
            end
        end

        drain_results();
        // Give stray pulses time to show up past the pipeline depth.
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (expected_codes.size() != 0)
            report_mismatch($sformatf("%0d codes never returned", expected_codes.size()));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
